[hw/rtl/camera_ray_direction_to_rgba_unit_macros.svh]
// Assertion macros shared by the camera ray direction to RGBA unit.
`ifndef CAMERA_RAY_DIRECTION_TO_RGBA_UNIT_MACROS_SVH
`define CAMERA_RAY_DIRECTION_TO_RGBA_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CRD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/crdrgba_pkg.sv]
// Shared widths, register codes and helper functions of the ray direction unit.
package crdrgba_pkg;

    localparam int SIDE_W      = 13;
    localparam int MAX_SIDE    = 4096;
    localparam int IDX_W       = 24;
    localparam int MAT_W       = 16;
    localparam int MSUM_W      = MAT_W + 1;
    localparam int BYTE_W      = 8;
    localparam int NORM_BITS   = 20;

    localparam int TXB_W       = SIDE_W + 2;
    localparam int TYB_W       = IDX_W + 3;
    localparam int TZ_W        = 2 * SIDE_W;
    localparam int TX_W        = TXB_W + SIDE_W + 1;
    localparam int TY_W        = TYB_W + SIDE_W + 1;
    localparam int P0_W        = MAT_W + TX_W;
    localparam int P1_W        = MAT_W + TY_W;
    localparam int P2_W        = MSUM_W + TZ_W + 1;
    localparam int D_W         = P1_W + 1;
    localparam int MAG_W       = D_W - 1;
    localparam int SH_W        = $clog2(MAG_W);
    localparam int A_W         = NORM_BITS;
    localparam int SQ_W        = 2 * A_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int RHS_W       = SQ_W + 16;
    localparam int ACC_W       = SUM_W + 2 * BYTE_W + 1;

    localparam int DIV_STAGES  = IDX_W;
    localparam int MID_STAGES  = 9;
    localparam int BYTE_STAGES = BYTE_W;
    localparam int LATENCY     = DIV_STAGES + MID_STAGES + BYTE_STAGES;

    localparam int APB_AW      = 6;
    localparam int APB_DW      = 64;

    localparam logic [15:0]       FULL_SCALE_SQ = 16'd65025;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE  = 8'hFF;

    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_MATRIX_COL0  = 3'd2;
    localparam logic [2:0] REG_MATRIX_COL1  = 3'd3;
    localparam logic [2:0] REG_MATRIX_COL2  = 3'd4;
    localparam logic [2:0] REG_MATRIX_COL3  = 3'd5;

    localparam logic [SIDE_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [SIDE_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [APB_DW-1:0] RST_COL0 = 64'h0000_0000_0000_1000;
    localparam logic [APB_DW-1:0] RST_COL1 = 64'h0000_0000_1000_0000;
    localparam logic [APB_DW-1:0] RST_COL2 = 64'h0000_1000_0000_0000;
    localparam logic [APB_DW-1:0] RST_COL3 = 64'h1000_0000_0000_0000;

    typedef logic signed [MAT_W-1:0] t_entry;

    // A zero side counts as one, an oversized side saturates.
    function automatic logic [SIDE_W-1:0] side_clamp(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_SIDE)) begin
            r = SIDE_W'(MAX_SIDE);
        end
        return r;
    endfunction

    function automatic t_entry entry_of(input logic [APB_DW-1:0] col, input int row);
        return t_entry'(col[MAT_W*row +: MAT_W]);
    endfunction

endpackage

[hw/rtl/crdrgba_divider.sv]
// Pipelined restoring divider: one quotient bit per stage, splits the index into row and column.
module crdrgba_divider (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [crdrgba_pkg::IDX_W-1:0]  i_dividend,
    input  logic [crdrgba_pkg::SIDE_W-1:0] i_divisor,
    output logic [crdrgba_pkg::IDX_W-1:0]  o_quotient,
    output logic [crdrgba_pkg::SIDE_W-1:0] o_remainder
);
    import crdrgba_pkg::*;

    logic [SIDE_W-1:0] r_rem [DIV_STAGES];
    logic [IDX_W-1:0]  r_num [DIV_STAGES];
    logic [IDX_W-1:0]  r_quo [DIV_STAGES];

    logic [SIDE_W-1:0] c_rem [DIV_STAGES+1];
    logic [IDX_W-1:0]  c_num [DIV_STAGES+1];
    logic [IDX_W-1:0]  c_quo [DIV_STAGES+1];

    assign c_rem[0] = '0;
    assign c_num[0] = i_dividend;
    assign c_quo[0] = '0;

    genvar j;
    generate
        for (j = 0; j < DIV_STAGES; j++) begin : g_stage
            logic [SIDE_W:0]   trial;
            logic              ge;
            logic [SIDE_W-1:0] n_rem;

            always_comb begin
                trial = {c_rem[j], c_num[j][IDX_W-1]};
                ge    = trial >= {1'b0, i_divisor};
                n_rem = ge ? SIDE_W'(trial - {1'b0, i_divisor}) : SIDE_W'(trial);
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= n_rem;
                    r_num[j] <= {c_num[j][IDX_W-2:0], 1'b0};
                    r_quo[j] <= {c_quo[j][IDX_W-2:0], ge};
                end
            end

            assign c_rem[j+1] = r_rem[j];
            assign c_num[j+1] = r_num[j];
            assign c_quo[j+1] = r_quo[j];
        end
    endgenerate

    assign o_quotient  = c_quo[DIV_STAGES];
    assign o_remainder = c_rem[DIV_STAGES];

endmodule

[hw/rtl/crdrgba_byte_search.sv]
// Pipelined bit-by-bit search for the largest byte k with k*k*S <= rhs.
module crdrgba_byte_search (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_keep,
    input  logic [crdrgba_pkg::RHS_W-1:0] i_rhs,
    input  logic [crdrgba_pkg::SUM_W-1:0] i_sum,
    output logic [crdrgba_pkg::BYTE_W-1:0] o_byte
);
    import crdrgba_pkg::*;

    // P holds k*k*S and Q holds k*S, so each trial is shifts and adds only.
    logic [BYTE_W-1:0] r_k    [BYTE_STAGES];
    logic [ACC_W-1:0]  r_p    [BYTE_STAGES];
    logic [ACC_W-1:0]  r_q    [BYTE_STAGES];
    logic [SUM_W-1:0]  r_s    [BYTE_STAGES];
    logic [RHS_W-1:0]  r_rhs  [BYTE_STAGES];
    logic              r_keep [BYTE_STAGES];

    logic [BYTE_W-1:0] c_k    [BYTE_STAGES+1];
    logic [ACC_W-1:0]  c_p    [BYTE_STAGES+1];
    logic [ACC_W-1:0]  c_q    [BYTE_STAGES+1];
    logic [SUM_W-1:0]  c_s    [BYTE_STAGES+1];
    logic [RHS_W-1:0]  c_rhs  [BYTE_STAGES+1];
    logic              c_keep [BYTE_STAGES+1];

    assign c_k[0]    = '0;
    assign c_p[0]    = '0;
    assign c_q[0]    = '0;
    assign c_s[0]    = i_sum;
    assign c_rhs[0]  = i_rhs;
    assign c_keep[0] = i_keep;

    genvar j;
    generate
        for (j = 0; j < BYTE_STAGES; j++) begin : g_stage
            localparam int B = BYTE_STAGES - 1 - j;
            logic [ACC_W-1:0] trial;
            logic             take;

            always_comb begin
                trial = c_p[j] + (c_q[j] << (B + 1)) + (ACC_W'(c_s[j]) << (2 * B));
                take  = trial <= ACC_W'(c_rhs[j]);
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_k[j]    <= take ? (c_k[j] | BYTE_W'(1 << B)) : c_k[j];
                    r_p[j]    <= take ? trial : c_p[j];
                    r_q[j]    <= take ? (c_q[j] + (ACC_W'(c_s[j]) << B)) : c_q[j];
                    r_s[j]    <= c_s[j];
                    r_rhs[j]  <= c_rhs[j];
                    r_keep[j] <= c_keep[j];
                end
            end

            assign c_k[j+1]    = r_k[j];
            assign c_p[j+1]    = r_p[j];
            assign c_q[j+1]    = r_q[j];
            assign c_s[j+1]    = r_s[j];
            assign c_rhs[j+1]  = r_rhs[j];
            assign c_keep[j+1] = r_keep[j];
        end
    endgenerate

    assign o_byte = c_keep[BYTE_STAGES] ? c_k[BYTE_STAGES] : '0;

endmodule

[hw/rtl/camera_ray_direction_to_rgba_unit.sv]
// Top level: pixel index to normalized camera ray direction packed as RGBA bytes.
//
//   channel  direction  handshake                  payload
//   in       to unit    i_in_valid / o_in_stall    i_pixel_index, i_last_pixel
//   out      from unit  o_out_valid / i_out_stall  o_red, o_green, o_blue, o_alpha, o_last_out
//   config   to unit    APB psel / penable         paddr, pwdata, prdata
//
// One pixel enters per cycle while o_in_stall is low.
// The pipeline is the 24-stage index divider, nine arithmetic stages and the
// eight-stage byte search. Reset clears every valid bit and loads the default registers.
// The whole pipeline holds while a result waits on a stalled output; bubbles move otherwise.
`include "camera_ray_direction_to_rgba_unit_macros.svh"

module camera_ray_direction_to_rgba_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [crdrgba_pkg::APB_AW-1:0]    paddr,
    input  logic [crdrgba_pkg::APB_DW-1:0]    pwdata,
    output logic [crdrgba_pkg::APB_DW-1:0]    prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [crdrgba_pkg::IDX_W-1:0]     i_pixel_index,
    input  logic                              i_last_pixel,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [crdrgba_pkg::BYTE_W-1:0]    o_red,
    output logic [crdrgba_pkg::BYTE_W-1:0]    o_green,
    output logic [crdrgba_pkg::BYTE_W-1:0]    o_blue,
    output logic [crdrgba_pkg::BYTE_W-1:0]    o_alpha,
    output logic                              o_last_out
);
    import crdrgba_pkg::*;

    // Configuration registers
    logic [SIDE_W-1:0] r_frame_width;
    logic [SIDE_W-1:0] r_frame_height;
    logic [APB_DW-1:0] r_col [4];
    logic [2:0]        reg_idx;
    logic              cfg_we;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:3];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_col[0]       <= RST_COL0;
            r_col[1]       <= RST_COL1;
            r_col[2]       <= RST_COL2;
            r_col[3]       <= RST_COL3;
        end else if (cfg_we) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[SIDE_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[SIDE_W-1:0];
                REG_MATRIX_COL0:  r_col[0]       <= pwdata;
                REG_MATRIX_COL1:  r_col[1]       <= pwdata;
                REG_MATRIX_COL2:  r_col[2]       <= pwdata;
                REG_MATRIX_COL3:  r_col[3]       <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            REG_MATRIX_COL0:  prdata = r_col[0];
            REG_MATRIX_COL1:  prdata = r_col[1];
            REG_MATRIX_COL2:  prdata = r_col[2];
            REG_MATRIX_COL3:  prdata = r_col[3];
            default:          prdata = '0;
        endcase
    end

    logic [SIDE_W-1:0] w_side;
    logic [SIDE_W-1:0] h_side;
    assign w_side = side_clamp(r_frame_width);
    assign h_side = side_clamp(r_frame_height);

    // Pipeline control: everything advances unless a result is held on the output.
    logic                r_vld [LATENCY];
    logic                r_lst [LATENCY];
    logic                en;

    assign en         = !r_vld[LATENCY-1] || !i_out_stall;
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LATENCY; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int i = 1; i < LATENCY; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lst[0] <= i_last_pixel;
            for (int i = 1; i < LATENCY; i++) begin
                r_lst[i] <= r_lst[i-1];
            end
        end
    end

    // Row and column of the pixel
    logic [IDX_W-1:0]  div_y;
    logic [SIDE_W-1:0] div_x;

    crdrgba_divider u_divider (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_dividend  (i_pixel_index),
        .i_divisor   (w_side),
        .o_quotient  (div_y),
        .o_remainder (div_x)
    );

    // Stage 1: clip offsets and the area term
    logic signed [TXB_W-1:0] r_txb;
    logic signed [TYB_W-1:0] r_tyb;
    logic [TZ_W-1:0]         r_tz;
    // Stage 2: scaled clip terms
    logic signed [TX_W-1:0]  r_tx;
    logic signed [TY_W-1:0]  r_ty;
    logic signed [TZ_W:0]    r_tzs;
    // Stage 3: matrix products
    logic signed [P0_W-1:0]  r_p0 [3];
    logic signed [P1_W-1:0]  r_p1 [3];
    logic signed [P2_W-1:0]  r_p2 [3];
    // Stage 4: direction components
    logic signed [D_W-1:0]   r_d [3];
    // Stage 5: magnitudes
    logic [MAG_W-1:0]        r_mag5 [3];
    logic                    r_pos5 [3];
    // Stage 6: normalizing shift
    logic [MAG_W-1:0]        r_mag6 [3];
    logic                    r_pos6 [3];
    logic [SH_W-1:0]         r_sh;
    // Stage 7: reduced magnitudes
    logic [A_W-1:0]          r_a [3];
    logic                    r_pos7 [3];
    // Stage 8: squares
    logic [SQ_W-1:0]         r_sq [3];
    logic                    r_keep8 [3];
    // Stage 9: squared length and right-hand sides
    logic [SUM_W-1:0]        r_sum;
    logic [RHS_W-1:0]        r_rhs [3];
    logic                    r_keep9 [3];

    logic signed [MSUM_W-1:0] msum [3];
    logic [MAG_W-1:0]         mag_or;
    logic [SH_W-1:0]          n_sh;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            msum[i] = $signed(MSUM_W'(entry_of(r_col[2], i))) +
                      $signed(MSUM_W'(entry_of(r_col[3], i)));
        end
        mag_or = r_mag5[0] | r_mag5[1] | r_mag5[2];
        // The shift brings the largest magnitude below 2^NORM_BITS.
        n_sh = '0;
        for (int b = NORM_BITS; b < MAG_W; b++) begin
            if (mag_or[b]) begin
                n_sh = SH_W'(b - NORM_BITS + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_txb <= $signed(TXB_W'(w_side)) - $signed(TXB_W'({div_x, 1'b0}));
            r_tyb <= $signed(TYB_W'(h_side)) - $signed(TYB_W'({div_y, 1'b0}));
            r_tz  <= TZ_W'(w_side) * TZ_W'(h_side);

            r_tx  <= $signed(TX_W'(r_txb)) * $signed(TX_W'({1'b0, h_side}));
            r_ty  <= $signed(TY_W'(r_tyb)) * $signed(TY_W'({1'b0, w_side}));
            r_tzs <= $signed({1'b0, r_tz});

            for (int i = 0; i < 3; i++) begin
                r_p0[i] <= $signed(P0_W'(entry_of(r_col[0], i))) * $signed(P0_W'(r_tx));
                r_p1[i] <= $signed(P1_W'(entry_of(r_col[1], i))) * $signed(P1_W'(r_ty));
                r_p2[i] <= $signed(P2_W'(msum[i])) * $signed(P2_W'(r_tzs));

                r_d[i]  <= $signed(D_W'(r_p0[i])) + $signed(D_W'(r_p1[i])) +
                           $signed(D_W'(r_p2[i]));

                r_pos5[i] <= !r_d[i][D_W-1] && (r_d[i] != '0);
                r_mag5[i] <= r_d[i][D_W-1] ? MAG_W'(-r_d[i]) : MAG_W'(r_d[i]);

                r_mag6[i] <= r_mag5[i];
                r_pos6[i] <= r_pos5[i];

                r_a[i]    <= A_W'(r_mag6[i] >> r_sh);
                r_pos7[i] <= r_pos6[i];

                r_sq[i]    <= SQ_W'(r_a[i]) * SQ_W'(r_a[i]);
                r_keep8[i] <= r_pos7[i] && (r_a[i] != '0);

                r_rhs[i]   <= RHS_W'(FULL_SCALE_SQ) * RHS_W'(r_sq[i]);
                r_keep9[i] <= r_keep8[i];
            end
            r_sh  <= n_sh;
            r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
        end
    end

    logic [BYTE_W-1:0] bytes [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_lane
            crdrgba_byte_search u_byte_search (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_keep (r_keep9[g]),
                .i_rhs  (r_rhs[g]),
                .i_sum  (r_sum),
                .o_byte (bytes[g])
            );
        end
    endgenerate

    assign o_out_valid = r_vld[LATENCY-1];
    assign o_last_out  = r_lst[LATENCY-1];
    assign o_red       = bytes[0];
    assign o_green     = bytes[1];
    assign o_blue      = bytes[2];
    assign o_alpha     = ALPHA_OPAQUE;

    `CRD_ASSERT_SAME(a_hold_stalls_input, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)
    `CRD_ASSERT_NEXT(a_transfer_enters, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_vld[0])
    `CRD_ASSERT_SAME(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid)

endmodule
